@@ design/swns_pkg.sv @@
// Shared types, mode codes and phase-step constants for the square wave / noise synth.
// No dependencies; imported by every module of the block.
package swns_pkg;

   localparam logic [1:0] MODE_OPEN  = 2'd1;
   localparam logic [1:0] MODE_HALVE = 2'd2;

   localparam int PHASE_SCALE = 65536;
   localparam int SAMPLE_RATE = 22050;

   // Phase increments, floor(f * 65536 / 22050), folded at elaboration.
   localparam logic [15:0] STEP_LOW       = 16'(330 * PHASE_SCALE / SAMPLE_RATE);
   localparam logic [15:0] STEP_MID       = 16'(392 * PHASE_SCALE / SAMPLE_RATE);
   localparam logic [15:0] STEP_HIGH      = 16'(494 * PHASE_SCALE / SAMPLE_RATE);
   localparam logic [15:0] STEP_HARM_LOW  = 16'((330 * 3 / 2) * PHASE_SCALE / SAMPLE_RATE);
   localparam logic [15:0] STEP_HARM_MID  = 16'((392 * 3 / 2) * PHASE_SCALE / SAMPLE_RATE);
   localparam logic [15:0] STEP_HARM_HIGH = 16'((494 * 3 / 2) * PHASE_SCALE / SAMPLE_RATE);
   localparam logic [15:0] STEP_HARM_OPEN = 16'(659 * PHASE_SCALE / SAMPLE_RATE);

   // (2^17 + 1) / 3: x * RECIP_3 >> 17 == x / 3 for any 16-bit x
   localparam logic [16:0] RECIP_3 = 17'h0AAAB;

   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam logic [15:0] LFSR_SEED = 16'h0001;

   typedef enum logic [1:0] {
      NOTE_LOW  = 2'd0,
      NOTE_MID  = 2'd1,
      NOTE_HIGH = 2'd2,
      NOTE_OPEN = 2'd3
   } note_type;

   // One classified transaction as it sits in the queue.
   typedef struct packed {
      note_type   note;
      logic [1:0] sync_level;
      logic       effect;
      logic       halve;
      logic       muted;
   } entry_type;

   function automatic logic [15:0] main_step(input note_type n);
      logic [15:0] s;
      unique case (n)
         NOTE_LOW:  s = STEP_LOW;
         NOTE_MID:  s = STEP_MID;
         NOTE_HIGH: s = STEP_HIGH;
         NOTE_OPEN: s = STEP_HIGH;
         default:   s = STEP_HIGH;
      endcase
      return s;
   endfunction

   function automatic logic [15:0] harm_step(input note_type n);
      logic [15:0] s;
      unique case (n)
         NOTE_LOW:  s = STEP_HARM_LOW;
         NOTE_MID:  s = STEP_HARM_MID;
         NOTE_HIGH: s = STEP_HARM_HIGH;
         NOTE_OPEN: s = STEP_HARM_OPEN;
         default:   s = STEP_HARM_OPEN;
      endcase
      return s;
   endfunction

endpackage

@@ design/swns_front.sv @@
// Front end: classifies one tick transaction into a queue entry (note, flags).
// Depends on swns_pkg.
module swns_front
   import swns_pkg::*;
(
   input  logic        [1:0]  sound_mode,
   input  logic        [15:0] turn_number,
   input  logic               archived,
   input  logic        [1:0]  sync_level,
   input  logic               effect_active,
   input  logic               muted,
   output entry_type          entry
);

   logic [32:0] prod;
   logic [15:0] quot;
   logic [16:0] three_q;
   logic [16:0] rem_full;
   logic [1:0]  sel;
   logic [1:0]  idx;

   // turn mod 3 by reciprocal multiply
   always_comb begin
      prod     = 33'(turn_number) * 33'(RECIP_3);
      quot     = prod[32:17];
      three_q  = {quot, 1'b0} + {1'b0, quot};
      rem_full = {1'b0, turn_number} - three_q;
      sel      = rem_full[1:0];
      idx      = archived ? (2'd2 - sel) : sel;
   end

   always_comb begin
      if (sound_mode == MODE_OPEN) begin
         entry.note = NOTE_OPEN;
      end else begin
         unique case (idx)
            2'd0:    entry.note = NOTE_LOW;
            2'd1:    entry.note = NOTE_MID;
            default: entry.note = NOTE_HIGH;
         endcase
      end
      entry.sync_level = sync_level;
      entry.effect     = effect_active;
      entry.halve      = (sound_mode == MODE_HALVE);
      entry.muted      = muted;
   end

endmodule

@@ design/swns_queue.sv @@
// Short FIFO of classified entries between front and back ends.
// Depends on swns_pkg.
module swns_queue
   import swns_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff,  count_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

@@ design/swns_back.sv @@
// Back end: phase accumulators, noise LFSR, mixer and the output register.
// Depends on swns_pkg.
module swns_back
   import swns_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  entry_type          q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [11:0] rsp_sample
);

   logic        [15:0] main_phase_ff,    main_phase_in;
   logic        [15:0] harmony_phase_ff, harmony_phase_in;
   logic        [15:0] noise_ff,         noise_in;
   logic               valid_ff;
   logic signed [11:0] sample_ff,        sample_in;

   logic signed [11:0] sum;
   logic signed [11:0] saw;
   logic signed [11:0] noise_term;

   assign q_pop      = q_not_empty && (!valid_ff || rsp_ready);
   assign rsp_valid  = valid_ff;
   assign rsp_sample = sample_ff;

   always_comb begin
      main_phase_in    = main_phase_ff + main_step(q_head.note);
      harmony_phase_in = harmony_phase_ff + harm_step(q_head.note);
      noise_in         = (noise_ff >> 1) ^ (noise_ff[0] ? LFSR_TAPS : 16'h0000);

      saw        = $signed({4'b0000, harmony_phase_in[15:8]}) - 12'sd128;
      noise_term = $signed({6'b000000, noise_in[5:0]}) - 12'sd32;

      sum = main_phase_in[15] ? 12'sd260 : -12'sd260;
      if (q_head.sync_level != 2'd0) begin
         sum = sum + (harmony_phase_in[15] ? 12'sd110 : -12'sd110);
      end
      if (q_head.sync_level[1]) begin
         sum = sum + saw;
      end
      if (q_head.effect) begin
         sum = sum + (harmony_phase_in[14] ? 12'sd620 : -12'sd620) + noise_term;
      end
      // halve toward zero
      if (q_head.halve) begin
         sum = (sum + $signed({11'd0, sum[11]})) >>> 1;
      end
      sample_in = q_head.muted ? 12'sd0 : sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_phase_ff    <= '0;
         harmony_phase_ff <= '0;
         noise_ff         <= LFSR_SEED;
         valid_ff         <= 1'b0;
      end else if (q_pop) begin
         main_phase_ff    <= main_phase_in;
         harmony_phase_ff <= harmony_phase_in;
         noise_ff         <= noise_in;
         valid_ff         <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff         <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sample_ff <= sample_in;
      end
   end

   a_noise_alive: assert property (@(posedge clock) disable iff (reset)
      noise_ff != 16'h0000) else $error("noise LFSR locked at zero");
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !q_pop |=> $stable(main_phase_ff) && $stable(harmony_phase_ff))
      else $error("phase moved without a dequeue");
   a_pop_fills: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> valid_ff) else $error("dequeue did not load output");

endmodule

@@ design/square_wave_noise_synth_core.sv @@
// Top level of the square wave / noise synth: front classifier, entry queue, back mixer.
// Depends on swns_pkg, swns_front, swns_queue, swns_back.
//
//   channel | ports                       | direction | payload
//   --------+-----------------------------+-----------+-----------------------------------
//   req     | req_valid / req_ready       | in        | mode, turn, archived, sync, effect,
//           |                             |           | muted (one sample tick)
//   rsp     | rsp_valid / rsp_ready       | out       | rsp_sample, signed 12 bit PCM
//
// One transaction per clock sustained while rsp_ready stays high; each tick costs one
// pass through the back end's phase/LFSR/mix path, which updates state once per dequeue.
// The queue is written at acceptance; the back end dequeues and loads the output register
// together once no held sample blocks it, and rsp_valid rises from that load.
// Reset is synchronous; phases clear to zero, the LFSR loads one, no sweep.
// req_ready drops only when the queue is full; a sample held by a low rsp_ready stops
// the back end, and the queue absorbs input until it fills.
module square_wave_noise_synth_core
   import swns_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [1:0]  req_sound_mode,
   input  logic        [15:0] req_turn_number,
   input  logic               req_archived,
   input  logic        [1:0]  req_sync_level,
   input  logic               req_effect_active,
   input  logic               req_muted,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [11:0] rsp_sample
);

   entry_type new_entry;
   entry_type head_entry;
   logic      q_full;
   logic      q_not_empty;
   logic      q_pop;
   logic      q_push;

   // accept whenever the queue has room, independent of the output side
   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   // front: note choice (turn mod 3, archived reversal, open channel) and flags
   swns_front u_front (
      .sound_mode    (req_sound_mode),
      .turn_number   (req_turn_number),
      .archived      (req_archived),
      .sync_level    (req_sync_level),
      .effect_active (req_effect_active),
      .muted         (req_muted),
      .entry         (new_entry)
   );

   swns_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (new_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (head_entry)
   );

   // back: advances both phases and the LFSR per transaction, then mixes
   swns_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (head_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_sample  (rsp_sample)
   );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for square_wave_noise_synth_core: per-tick sample prediction,
// random idling on both channels, in-order comparison of every PCM sample.
// Depends on swns_pkg (mode codes) and the design under design/.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swns_pkg::*;

   // Mode codes the package leaves unnamed
   localparam logic [1:0] MODE_ORDINARY = 2'd0;
   localparam logic [1:0] MODE_SPARE    = 2'd3;

   // Tone and noise constants, kept apart from the design's own copies
   localparam int          HZ_LOW       = 330;
   localparam int          HZ_MID       = 392;
   localparam int          HZ_HIGH      = 494;
   localparam int          HZ_OPEN_HARM = 659;
   localparam int          PHASE_UNIT   = 65536;
   localparam int          TICK_RATE    = 22050;
   localparam logic [15:0] NOISE_TAPS   = 16'hB400;

   localparam int TICK_TARGET    = 1150;  // random ticks
   localparam int QUIET_TAIL     = 150;   // last ticks run with no idling
   localparam int DRAIN_CYCLES   = 8;     // idle cycles after the last owed sample is back
   localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction on either side
   localparam int MAX_REPORTS    = 10;

   // Tracks the synth state and holds the samples still owed by the DUT, oldest first.
   class synth_sample_tracker;
      logic [15:0]        tone_phase;
      logic [15:0]        chord_phase;
      logic [15:0]        noise_lfsr;
      logic signed [11:0] pending_samples[$];
      int                 mismatches;
      int                 checked;

      function new();
         tone_phase  = '0;
         chord_phase = '0;
         noise_lfsr  = 16'h0001;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function logic [15:0] phase_inc(int hz);
         return 16'(hz * PHASE_UNIT / TICK_RATE);
      endfunction

      function int motif_hz(int idx);
         case (idx)
            0:       return HZ_LOW;
            1:       return HZ_MID;
            default: return HZ_HIGH;
         endcase
      endfunction

      // One accepted tick: advance phases and LFSR, then mix the sample it produces.
      function void accept_tick(logic [1:0] mode, logic [15:0] turn, logic archived,
                                logic [1:0] sync, logic effect, logic muted);
         int pick;
         int note_hz;
         int harm_hz;
         int level;
         logic signed [11:0] sample;
         pick = int'(turn % 16'd3);
         if (mode == MODE_OPEN) begin
            note_hz = HZ_HIGH;
            harm_hz = HZ_OPEN_HARM;
         end else begin
            note_hz = motif_hz(archived ? 2 - pick : pick);
            harm_hz = note_hz * 3 / 2;
         end
         tone_phase  = tone_phase + phase_inc(note_hz);
         chord_phase = chord_phase + phase_inc(harm_hz);
         noise_lfsr  = (noise_lfsr >> 1) ^ (noise_lfsr[0] ? NOISE_TAPS : 16'h0000);

         level = tone_phase[15] ? 260 : -260;
         if (sync >= 2'd1)
            level += chord_phase[15] ? 110 : -110;
         if (sync >= 2'd2)
            level += int'(chord_phase[15:8]) - 128;
         if (effect)
            level += (chord_phase[14] ? 620 : -620) + int'(noise_lfsr[5:0]) - 32;
         if (mode == MODE_HALVE)
            level = level / 2;  // truncates toward zero
         if (muted)
            level = 0;
         sample = level[11:0];
         pending_samples.push_back(sample);
      endfunction

      function void report(string what, logic signed [11:0] want, logic signed [11:0] got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: sample #%0d expected %0d, got %0d",
                     $realtime, what, checked, want, got);
      endfunction

      function void check_sample(logic signed [11:0] got);
         logic signed [11:0] want;
         checked++;
         if (pending_samples.size() == 0) begin
            report("unexpected sample", 'x, got);
            return;
         end
         want = pending_samples.pop_front();
         if (got !== want)
            report("sample mismatch", want, got);
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and DUT connections; every input starts at a known value
   // ------------------------------------------------------------------
   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic        [1:0]  req_sound_mode    = '0;
   logic        [15:0] req_turn_number   = '0;
   logic               req_archived      = 1'b0;
   logic        [1:0]  req_sync_level    = '0;
   logic               req_effect_active = 1'b0;
   logic               req_muted         = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic signed [11:0] rsp_sample;

   synth_sample_tracker tracker = new();

   bit quiet_tail;          // set for the last stretch: no idling on either side
   int ticks_sent;
   int directed_ticks;
   int idle_cycles = 0;
   int mode_hits[4];
   int muted_ticks;
   int fx_ticks;
   int drain_pauses;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   square_wave_noise_synth_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sound_mode    (req_sound_mode),
      .req_turn_number   (req_turn_number),
      .req_archived      (req_archived),
      .req_sync_level    (req_sync_level),
      .req_effect_active (req_effect_active),
      .req_muted         (req_muted),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample        (rsp_sample)
   );

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------

   // Present one tick and hold it until the DUT takes it. An optional idle burst comes
   // first; in this task valid only drops for that burst, so back-to-back ticks keep it high.
   task automatic send_tick(input logic [1:0] mode, input logic [15:0] turn,
                            input logic archived, input logic [1:0] sync,
                            input logic effect, input logic muted);
      int gap;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sound_mode    <= mode;
      req_turn_number   <= turn;
      req_archived      <= archived;
      req_sync_level    <= sync;
      req_effect_active <= effect;
      req_muted         <= muted;
      do @(posedge clock); while (!req_ready);
      // the transaction went in at this edge; the state update follows acceptance order
      tracker.accept_tick(mode, turn, archived, sync, effect, muted);
      ticks_sent++;
      mode_hits[mode]++;
      if (muted)
         muted_ticks++;
      if (effect)
         fx_ticks++;
   endtask

   // Pause the sender until every owed sample is back
   task automatic drain_outputs();
      req_valid <= 1'b0;
      while (tracker.pending_samples.size() != 0)
         @(posedge clock);
      drain_pauses++;
   endtask

   function automatic logic [15:0] pick_turn();
      logic [15:0] edge_turns[6];
      edge_turns = '{16'd0, 16'd1, 16'd2, 16'd65533, 16'd65534, 16'd65535};
      if ($urandom_range(0, 7) == 0)
         return edge_turns[$urandom_range(0, 5)];
      return 16'($urandom_range(0, 65535));
   endfunction

   // Random part: runs of ticks that mostly keep one setting (as a real session would),
   // so the phases sweep through full periods, with occasional field changes inside a run.
   task automatic random_ticks();
      logic [1:0]  mode;
      logic [15:0] turn;
      logic        archived;
      logic [1:0]  sync;
      logic        effect;
      logic        muted;
      int          run_len;
      int          sent;
      sent = 0;
      while (sent < TICK_TARGET) begin
         mode     = 2'($urandom_range(0, 3));
         turn     = pick_turn();
         archived = 1'($urandom_range(0, 1));
         sync     = 2'($urandom_range(0, 3));
         effect   = 1'($urandom_range(0, 1));
         muted    = ($urandom_range(0, 9) == 0);
         run_len  = $urandom_range(1, 40);
         for (int k = 0; k < run_len && sent < TICK_TARGET; k++) begin
            if ($urandom_range(0, 9) == 0)
               turn = turn + 16'd1;          // next turn, wraps at the top
            if ($urandom_range(0, 19) == 0)
               turn = pick_turn();
            if ($urandom_range(0, 19) == 0)
               sync = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0)
               effect = ~effect;
            if ($urandom_range(0, 29) == 0)
               mode = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 29) == 0)
               archived = ~archived;
            if ($urandom_range(0, 29) == 0)
               muted = ~muted;
            quiet_tail = (sent >= TICK_TARGET - QUIET_TAIL);
            send_tick(mode, turn, archived, sync, effect, muted);
            sent++;
            if (sent % 300 == 0)
               drain_outputs();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver side: check each accepted sample, then pick next cycle's ready
   // ------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            tracker.check_sample(rsp_sample);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 4);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: counts cycles in which neither channel moves a transaction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("Watchdog: no transaction for %0d cycles, %0d samples still owed",
               WATCHDOG_LIMIT, tracker.pending_samples.size());
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      quiet_tail   = 1'b0;
      ticks_sent   = 0;
      muted_ticks  = 0;
      fx_ticks     = 0;
      drain_pauses = 0;
      foreach (mode_hits[m])
         mode_hits[m] = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every mode code, each motif slot in both orders, all sync levels,
      // turn extremes, halving, muting, the spare mode code treated as ordinary.
      send_tick(MODE_ORDINARY, 16'd0,     1'b0, 2'd0, 1'b0, 1'b0);
      send_tick(MODE_ORDINARY, 16'd1,     1'b0, 2'd1, 1'b0, 1'b0);
      send_tick(MODE_ORDINARY, 16'd2,     1'b0, 2'd2, 1'b0, 1'b0);
      send_tick(MODE_ORDINARY, 16'd0,     1'b1, 2'd3, 1'b0, 1'b0);
      send_tick(MODE_ORDINARY, 16'd1,     1'b1, 2'd3, 1'b1, 1'b0);
      send_tick(MODE_ORDINARY, 16'd2,     1'b1, 2'd0, 1'b1, 1'b0);
      send_tick(MODE_OPEN,     16'd0,     1'b0, 2'd3, 1'b1, 1'b0);
      send_tick(MODE_OPEN,     16'd65535, 1'b1, 2'd1, 1'b0, 1'b0);
      send_tick(MODE_HALVE,    16'd3,     1'b0, 2'd3, 1'b1, 1'b0);
      send_tick(MODE_HALVE,    16'd65535, 1'b0, 2'd2, 1'b1, 1'b0);
      send_tick(MODE_HALVE,    16'd65534, 1'b1, 2'd0, 1'b0, 1'b0);
      send_tick(MODE_HALVE,    16'd7,     1'b0, 2'd1, 1'b0, 1'b0);
      send_tick(MODE_SPARE,    16'd4,     1'b0, 2'd3, 1'b1, 1'b0);
      send_tick(MODE_SPARE,    16'd65533, 1'b1, 2'd2, 1'b0, 1'b0);
      send_tick(MODE_ORDINARY, 16'd9,     1'b0, 2'd3, 1'b1, 1'b1);
      send_tick(MODE_HALVE,    16'd10,    1'b1, 2'd3, 1'b1, 1'b1);
      send_tick(MODE_OPEN,     16'd11,    1'b0, 2'd0, 1'b1, 1'b1);
      send_tick(MODE_SPARE,    16'd12,    1'b1, 2'd1, 1'b0, 1'b1);
      send_tick(MODE_ORDINARY, 16'hAAAA,  1'b0, 2'd3, 1'b1, 1'b0);
      send_tick(MODE_ORDINARY, 16'h5555,  1'b1, 2'd3, 1'b1, 1'b0);
      send_tick(MODE_OPEN,     16'hFFFF,  1'b0, 2'd2, 1'b1, 1'b0);
      directed_ticks = ticks_sent;

      // hold off once with the pipeline fully drained before the random part
      drain_outputs();
      random_ticks();
      req_valid <= 1'b0;

      while (tracker.pending_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d ticks (%0d directed), %0d samples checked, %0d drain pauses",
               ticks_sent, directed_ticks, tracker.checked, drain_pauses);
      $display("Modes ordinary/open/halve/spare: %0d/%0d/%0d/%0d, muted %0d, effect %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
               muted_ticks, fx_ticks);
      if (tracker.mismatches == 0 && tracker.pending_samples.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d samples never delivered",
                  tracker.mismatches, tracker.pending_samples.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
